/* rtl/pgf_pkg.sv */
// Package for the pairwise gravity force unit: payload and register types,
// register indexes and pipeline depth constants. No dependencies.
`timescale 1ns / 1ps

package pgf_pkg;

	localparam int MAG_STEPS    = 64;
	localparam int SQRT_STEPS   = 32;
	localparam int FRC_STEPS    = 33;
	localparam int PIPE_LATENCY = MAG_STEPS + FRC_STEPS + 7;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	localparam logic [1:0] REG_GRAVITY  = 2'd0;
	localparam logic [1:0] REG_MIN_DIST = 2'd1;
	localparam logic [1:0] REG_MAX_DIST = 2'd2;

	localparam logic [31:0] GRAVITY_RESET  = 32'h0001_0000;
	localparam logic [47:0] MIN_DIST_RESET = 48'h0000_0001_0000;
	localparam logic [47:0] MAX_DIST_RESET = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [23:0] first_x;
		logic signed [23:0] first_y;
		logic [31:0]        first_mass;
		logic signed [23:0] second_x;
		logic signed [23:0] second_y;
		logic [31:0]        second_mass;
	} pgf_in_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic               saturated;
	} pgf_out_t;

	typedef struct packed {
		logic [31:0] gravity_constant;
		logic [47:0] min_dist_squared;
		logic [47:0] max_dist_squared;
	} pgf_cfg_t;

endpackage

/* rtl/pairwise_gravity_force_unit.sv */
// Top level of the pairwise gravity force unit: register port and datapath.
// Depends on pgf_pkg and pgf_datapath.
//
// Usage: raise start with a body pair on operands; busy is always low, so
// the pair transfers at that edge and a new pair may follow every cycle.
// Each pair gives one result: done is high for exactly one cycle with
// force_x, force_y and saturated on result, at the end of the pipeline
// (64 magnitude divide steps, 33 component divide steps, 7 other stages).
// The square root runs alongside the first 32 magnitude divide steps.
// Results appear in input order; the receiver cannot hold them off, so it
// must take each result in its done cycle.
// Registers sit on the APB-style port at byte addresses 0, 8 and 16
// (gravity constant, lower and upper squared distance bounds), 64-bit data.
// Write them only with the pipeline empty.
// Reset empties the pipeline and loads the register defaults: G = 1.0,
// lower bound 1.0, upper bound all ones.
`timescale 1ns / 1ps

module pairwise_gravity_force_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  pgf_pkg::pgf_in_t            operands,
	output logic                        done,
	output pgf_pkg::pgf_out_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pgf_pkg::ADDR_W-1:0]  paddr,
	input  logic [pgf_pkg::DATA_W-1:0]  pwdata,
	output logic [pgf_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import pgf_pkg::*;

	pgf_cfg_t   cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:3];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity_constant <= GRAVITY_RESET;
			cfg_q.min_dist_squared <= MIN_DIST_RESET;
			cfg_q.max_dist_squared <= MAX_DIST_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GRAVITY:  cfg_q.gravity_constant <= pwdata[31:0];
				REG_MIN_DIST: cfg_q.min_dist_squared <= pwdata[47:0];
				REG_MAX_DIST: cfg_q.max_dist_squared <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GRAVITY:  prdata = 64'(cfg_q.gravity_constant);
			REG_MIN_DIST: prdata = 64'(cfg_q.min_dist_squared);
			REG_MAX_DIST: prdata = 64'(cfg_q.max_dist_squared);
			default:      prdata = '0;
		endcase
	end

	pgf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.in_data   (operands),
		.cfg       (cfg_q),
		.out_valid (done),
		.out_data  (result)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, PIPE_LATENCY))
		else $error("result without a matching transfer");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start, PIPE_LATENCY) && $past(arst_n, PIPE_LATENCY) |-> done)
		else $error("transfer without a result");

	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.saturated |->
			(result.force_x == 32'sh7FFF_FFFF) || (result.force_x == 32'sh8000_0000) ||
			(result.force_y == 32'sh7FFF_FFFF) || (result.force_y == 32'sh8000_0000))
		else $error("saturation flag without a limit value");

endmodule

/* rtl/pgf_datapath.sv */
// Pipelined datapath of the gravity force unit: differences, products, clamp,
// bit-serial magnitude divide, square root and component divides.
// Depends on pgf_pkg.
`timescale 1ns / 1ps

module pgf_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  pgf_pkg::pgf_in_t  in_data,
	input  pgf_pkg::pgf_cfg_t cfg,
	output logic              out_valid,
	output pgf_pkg::pgf_out_t out_data
);
	import pgf_pkg::*;

	typedef struct packed {
		logic               zero;
		logic               msat;
		logic [47:0]        den;
		logic [63:0]        num;
		logic [47:0]        rem;
		logic [63:0]        quo;
		logic [63:0]        sq_v;
		logic [33:0]        sq_rem;
		logic [31:0]        sq_root;
		logic signed [24:0] dx;
		logic signed [24:0] dy;
	} mag_stage_t;

	typedef struct packed {
		logic        ovf;
		logic        neg;
		logic [31:0] rem;
		logic [32:0] num;
		logic [32:0] quo;
	} comp_t;

	typedef struct packed {
		logic        zero;
		logic [31:0] len;
		comp_t       cx;
		comp_t       cy;
	} frc_stage_t;

	function automatic comp_t comp_step(input comp_t c, input logic [31:0] den);
		logic [32:0] r2;
		comp_t n;
		n = c;
		r2 = {c.rem, c.num[32]};
		n.num = {c.num[31:0], 1'b0};
		if (r2 >= {1'b0, den}) begin
			n.rem = 32'(r2 - {1'b0, den});
			n.quo = {c.quo[31:0], 1'b1};
		end else begin
			n.rem = r2[31:0];
			n.quo = {c.quo[31:0], 1'b0};
		end
		return n;
	endfunction

	function automatic logic [32:0] comp_final(input comp_t c);
		logic [32:0] r;
		if (!c.neg) begin
			if (c.ovf || c.quo > 33'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, c.quo[31:0]};
		end else begin
			if (c.ovf || c.quo > 33'h0_8000_0000) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, 32'd0 - c.quo[31:0]};
		end
		return r;
	endfunction

	// stage 1: differences and first mass product
	logic               v_s1;
	logic signed [24:0] dx_s1, dy_s1;
	logic [63:0]        gm_s1;
	logic [31:0]        mb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		dx_s1 <= 25'(in_data.second_x) - 25'(in_data.first_x);
		dy_s1 <= 25'(in_data.second_y) - 25'(in_data.first_y);
		gm_s1 <= cfg.gravity_constant * in_data.first_mass;
		mb_s1 <= in_data.second_mass;
	end

	// stage 2: squares and partial products
	logic               v_s2;
	logic signed [24:0] dx_s2, dy_s2;
	logic [48:0]        sqx_s2, sqy_s2;
	logic [63:0]        plo_s2, phi_s2;
	logic signed [49:0] sqx, sqy;

	assign sqx = dx_s1 * dx_s1;
	assign sqy = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		dx_s2  <= dx_s1;
		dy_s2  <= dy_s1;
		sqx_s2 <= sqx[48:0];
		sqy_s2 <= sqy[48:0];
		plo_s2 <= gm_s1[31:0] * mb_s1;
		phi_s2 <= gm_s1[63:32] * mb_s1;
	end

	// stage 3: sums
	logic               v_s3;
	logic signed [24:0] dx_s3, dy_s3;
	logic [49:0]        d2_s3;
	logic [95:0]        num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		dx_s3  <= dx_s2;
		dy_s3  <= dy_s2;
		d2_s3  <= 50'(sqx_s2) + 50'(sqy_s2);
		num_s3 <= 96'(plo_s2) + {phi_s2, 32'd0};
	end

	// stage 4: clamp and set up the divide and root
	logic [49:0] c_lo;
	logic [47:0] c_cl;
	logic        mag_ovf;
	mag_stage_t  mag_in;

	always_comb begin
		c_lo = (d2_s3 < 50'(cfg.min_dist_squared)) ? 50'(cfg.min_dist_squared) : d2_s3;
		c_cl = (c_lo > 50'(cfg.max_dist_squared)) ? cfg.max_dist_squared : c_lo[47:0];
		mag_ovf = 48'(num_s3[95:80]) >= c_cl;
		mag_in.zero    = (d2_s3 == 50'd0);
		mag_in.msat    = mag_ovf || (c_cl == 48'd0);
		mag_in.den     = c_cl;
		mag_in.num     = num_s3[79:16];
		mag_in.rem     = 48'(num_s3[95:80]);
		mag_in.quo     = 64'd0;
		mag_in.sq_v    = {d2_s3, 14'd0};
		mag_in.sq_rem  = 34'd0;
		mag_in.sq_root = 32'd0;
		mag_in.dx      = dx_s3;
		mag_in.dy      = dy_s3;
	end

	mag_stage_t       mag_s [0:MAG_STEPS];
	logic [MAG_STEPS:0] magv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) magv_s[0] <= 1'b0;
		else magv_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		mag_s[0] <= mag_in;
	end

	for (genvar k = 0; k < MAG_STEPS; k++) begin : g_mag
		mag_stage_t  nxt;
		logic [48:0] r2;
		logic [35:0] t;
		logic [35:0] trial;

		always_comb begin
			nxt = mag_s[k];
			r2 = {mag_s[k].rem, mag_s[k].num[63]};
			nxt.num = {mag_s[k].num[62:0], 1'b0};
			if (r2 >= {1'b0, mag_s[k].den}) begin
				nxt.rem = 48'(r2 - {1'b0, mag_s[k].den});
				nxt.quo = {mag_s[k].quo[62:0], 1'b1};
			end else begin
				nxt.rem = r2[47:0];
				nxt.quo = {mag_s[k].quo[62:0], 1'b0};
			end
			t = {mag_s[k].sq_rem, mag_s[k].sq_v[63:62]};
			trial = {2'b00, mag_s[k].sq_root, 2'b01};
			if (k < SQRT_STEPS) begin
				nxt.sq_v = {mag_s[k].sq_v[61:0], 2'b00};
				if (t >= trial) begin
					nxt.sq_rem  = 34'(t - trial);
					nxt.sq_root = {mag_s[k].sq_root[30:0], 1'b1};
				end else begin
					nxt.sq_rem  = t[33:0];
					nxt.sq_root = {mag_s[k].sq_root[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) magv_s[k+1] <= 1'b0;
			else magv_s[k+1] <= magv_s[k];
		end

		always_ff @(posedge clk) begin
			mag_s[k+1] <= nxt;
		end
	end

	// component products
	mag_stage_t  mag_last;
	logic [63:0] mag;
	logic [24:0] ax, ay;

	assign mag_last = mag_s[MAG_STEPS];
	assign mag = mag_last.msat ? '1 : mag_last.quo;
	assign ax  = mag_last.dx[24] ? 25'(-mag_last.dx) : 25'(mag_last.dx);
	assign ay  = mag_last.dy[24] ? 25'(-mag_last.dy) : 25'(mag_last.dy);

	logic        v_s5;
	logic        zero_s5, nx_s5, ny_s5;
	logic [31:0] len_s5;
	logic [56:0] pxl_s5, pxh_s5, pyl_s5, pyh_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= magv_s[MAG_STEPS];
	end

	always_ff @(posedge clk) begin
		zero_s5 <= mag_last.zero;
		nx_s5   <= mag_last.dx[24];
		ny_s5   <= mag_last.dy[24];
		len_s5  <= mag_last.sq_root;
		pxl_s5  <= mag[31:0] * ax;
		pxh_s5  <= mag[63:32] * ax;
		pyl_s5  <= mag[31:0] * ay;
		pyh_s5  <= mag[63:32] * ay;
	end

	// component divide set-up
	logic [95:0] pwx, pwy;
	frc_stage_t  frc_in;

	always_comb begin
		pwx = {89'(pxl_s5) + {pxh_s5, 32'd0}, 7'd0};
		pwy = {89'(pyl_s5) + {pyh_s5, 32'd0}, 7'd0};
		frc_in.zero   = zero_s5;
		frc_in.len    = len_s5;
		frc_in.cx.ovf = pwx[95:33] >= 63'(len_s5);
		frc_in.cx.neg = nx_s5;
		frc_in.cx.rem = pwx[64:33];
		frc_in.cx.num = pwx[32:0];
		frc_in.cx.quo = 33'd0;
		frc_in.cy.ovf = pwy[95:33] >= 63'(len_s5);
		frc_in.cy.neg = ny_s5;
		frc_in.cy.rem = pwy[64:33];
		frc_in.cy.num = pwy[32:0];
		frc_in.cy.quo = 33'd0;
	end

	frc_stage_t         frc_s [0:FRC_STEPS];
	logic [FRC_STEPS:0] frcv_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) frcv_s[0] <= 1'b0;
		else frcv_s[0] <= v_s5;
	end

	always_ff @(posedge clk) begin
		frc_s[0] <= frc_in;
	end

	for (genvar k = 0; k < FRC_STEPS; k++) begin : g_frc
		frc_stage_t nxt;

		always_comb begin
			nxt = frc_s[k];
			nxt.cx = comp_step(frc_s[k].cx, frc_s[k].len);
			nxt.cy = comp_step(frc_s[k].cy, frc_s[k].len);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) frcv_s[k+1] <= 1'b0;
			else frcv_s[k+1] <= frcv_s[k];
		end

		always_ff @(posedge clk) begin
			frc_s[k+1] <= nxt;
		end
	end

	// saturate and register the result
	logic [32:0] fx, fy;
	pgf_out_t    res;

	assign fx = comp_final(frc_s[FRC_STEPS].cx);
	assign fy = comp_final(frc_s[FRC_STEPS].cy);

	always_comb begin
		if (frc_s[FRC_STEPS].zero) begin
			res.force_x   = 32'sd0;
			res.force_y   = 32'sd0;
			res.saturated = 1'b0;
		end else begin
			res.force_x   = fx[31:0];
			res.force_y   = fy[31:0];
			res.saturated = fx[32] | fy[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else out_valid <= frcv_s[FRC_STEPS];
	end

	always_ff @(posedge clk) begin
		out_data <= res;
	end

endmodule
